// ----- sv/sida_pkg.sv -----
`timescale 1ns / 1ps
package sida_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int CHAR_W          = 6;
	localparam int BITS_PER_STEP   = 4;
	localparam int Q_DEPTH         = 2;
	localparam int Q_PTR_W         = 1;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [3:0]        DIGIT_MAX  = 4'd9;

	// Decimal digits needed for any unsigned number of the given width.
	function automatic int digit_count(input int width);
		digit_count = ((width * 1233) >> 12) + 1;
	endfunction

	// Width rounded up to whole conversion steps.
	function automatic int step_width(input int width);
		step_width = ((width + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
	endfunction

endpackage

// ----- sv/sida_front.sv -----
`timescale 1ns / 1ps
module sida_front import sida_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          q_push,
	input  logic                          q_full,
	output logic [VALUE_WIDTH:0]          q_data
);

	logic                   valid_s1;
	logic                   neg_s1;
	logic [VALUE_WIDTH-1:0] mag_s1;
	logic                   accept;
	logic                   neg_in;
	logic [VALUE_WIDTH-1:0] mag_in;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_data = {neg_s1, mag_s1};

	// The most negative value negates to itself, which read unsigned is its magnitude.
	assign neg_in = value[VALUE_WIDTH-1];
	assign mag_in = neg_in ? (~value + 1'b1) : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_s1 <= neg_in;
			mag_s1 <= mag_in;
		end
	end

endmodule

// ----- sv/sida_queue.sv -----
`timescale 1ns / 1ps
module sida_queue import sida_pkg::*; #(
	parameter int WIDTH = VALUE_WIDTH_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0]   mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= wdata;
	end

endmodule

// ----- sv/sida_back.sv -----
`timescale 1ns / 1ps
module sida_back import sida_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	output logic              q_pop,
	input  logic [VALUE_WIDTH:0] q_data,
	output logic              empty,
	input  logic              pop,
	output logic [CHAR_W-1:0] character,
	output logic              last_char
);

	localparam int MAG_W  = step_width(VALUE_WIDTH);
	localparam int STEPS  = MAG_W / BITS_PER_STEP;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int DIG_N  = digit_count(VALUE_WIDTH);
	localparam int BCD_W  = DIG_N * 4;
	localparam int IDX_W  = $clog2(DIG_N);

	// converter
	logic              conv_busy_q;
	logic              conv_done_q;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic              conv_neg_q;
	logic [MAG_W-1:0]  bin_n;
	logic [BCD_W-1:0]  bcd_n;
	logic [IDX_W-1:0]  lead_idx;

	// emitter
	logic              emit_busy_q;
	logic              sign_pend_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BCD_W-1:0]  dig_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] character_q;
	logic              last_q;
	logic              emit_load;
	logic              out_free;
	logic              emit_step;
	logic [3:0]        cur_digit;

	assign q_pop     = !conv_busy_q && !conv_done_q && !q_empty;
	assign emit_load = conv_done_q && !emit_busy_q;
	assign out_free  = !out_valid_q || pop;
	assign emit_step = emit_busy_q && out_free;
	assign cur_digit = dig_q[idx_q*4 +: 4];

	assign empty     = !out_valid_q;
	assign character = character_q;
	assign last_char = last_q;

	// Shift-and-add-3, several bits per cycle.
	always_comb begin
		bcd_n = bcd_q;
		bin_n = bin_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			for (int d = 0; d < DIG_N; d++) begin
				if (bcd_n[d*4 +: 4] > 4'd4) bcd_n[d*4 +: 4] = bcd_n[d*4 +: 4] + 4'd3;
			end
			{bcd_n, bin_n} = {bcd_n, bin_n} << 1;
		end
	end

	// Highest nonzero digit; zero leaves index 0 so a single '0' goes out.
	always_comb begin
		lead_idx = '0;
		for (int d = 0; d < DIG_N; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) lead_idx = IDX_W'(d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_busy_q <= 1'b0;
			conv_done_q <= 1'b0;
			step_q      <= '0;
		end else if (q_pop) begin
			conv_busy_q <= 1'b1;
			step_q      <= '0;
		end else if (conv_busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(STEPS - 1)) begin
				conv_busy_q <= 1'b0;
				conv_done_q <= 1'b1;
			end
		end else if (emit_load) begin
			conv_done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bin_q      <= MAG_W'(q_data[VALUE_WIDTH-1:0]);
			bcd_q      <= '0;
			conv_neg_q <= q_data[VALUE_WIDTH];
		end else if (conv_busy_q) begin
			bin_q <= bin_n;
			bcd_q <= bcd_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_busy_q <= 1'b0;
			sign_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load) begin
				emit_busy_q <= 1'b1;
				sign_pend_q <= conv_neg_q;
			end else if (emit_step) begin
				if (sign_pend_q) begin
					sign_pend_q <= 1'b0;
				end else if (idx_q == '0) begin
					emit_busy_q <= 1'b0;
				end
			end
			if (emit_step) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			idx_q <= lead_idx;
			dig_q <= bcd_q;
		end else if (emit_step && !sign_pend_q && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
		if (emit_step) begin
			if (sign_pend_q) begin
				character_q <= CHAR_MINUS;
				last_q      <= 1'b0;
			end else begin
				character_q <= CHAR_ZERO + CHAR_W'(cur_digit);
				last_q      <= (idx_q == '0);
			end
		end
	end

	a_conv_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(conv_busy_q && conv_done_q))
		else $error("converter busy and done at once");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> emit_busy_q && !conv_done_q)
		else $error("emitter load did not take the converted item");

	a_sign_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sign_pend_q |-> emit_busy_q)
		else $error("sign pending outside an item");

	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (character_q == CHAR_MINUS ||
			(character_q >= CHAR_ZERO && character_q <= CHAR_ZERO + CHAR_W'(DIGIT_MAX))))
		else $error("character is neither minus nor digit");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && character_q == CHAR_MINUS) |-> !last_q)
		else $error("minus sign flagged as last");

endmodule

// ----- sv/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// Each item is loaded from the queue into the converter, runs the shift-and-add-3 steps and is
// then handed to the emitter, which sends the minus sign, if any, and the digits; characters leave
// at one per cycle while pop keeps the output free, and the converter can take the next item while
// the emitter is still sending the last one.
// Reset (arst_n low) empties the input stage, the queue, the converter and the output.
module signed_int_to_decimal_ascii import sida_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          empty,
	input  logic                          pop,
	output logic [CHAR_W-1:0]             character,
	output logic                          last_char
);

	logic                 f_push;
	logic                 f_full;
	logic [VALUE_WIDTH:0] f_data;
	logic                 b_pop;
	logic                 b_empty;
	logic [VALUE_WIDTH:0] b_data;

	sida_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.value  (value),
		.q_push (f_push),
		.q_full (f_full),
		.q_data (f_data)
	);

	sida_queue #(.WIDTH(VALUE_WIDTH + 1)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (f_full),
		.wdata  (f_data),
		.pop    (b_pop),
		.empty  (b_empty),
		.rdata  (b_data)
	);

	sida_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (b_empty),
		.q_pop     (b_pop),
		.q_data    (b_data),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last_char (last_char)
	);

endmodule

// ----- tb/tb_signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
module tb_signed_int_to_decimal_ascii;
	import sida_pkg::*;

	localparam int VW          = VALUE_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = 4 * VW;

	localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_exp_t;

	typedef enum logic [1:0] {
		POP_ALWAYS,
		POP_RANDOM,
		POP_SLOW,
		POP_RARE
	} pop_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic signed [VW-1:0] value;
	logic                 empty;
	logic                 pop;
	logic [CHAR_W-1:0]    character;
	logic                 last_char;

	char_exp_t expected_chars[$];
	int        errors;
	int        cycles;
	int        values_sent;
	int        negatives_sent;
	int        chars_checked;
	int        burst_left;
	int        mode_left;
	pop_mode_t pop_mode;

	signed_int_to_decimal_ascii #(.VALUE_WIDTH(VW)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last_char (last_char)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Append the decimal text of v, most significant character first.
	function automatic void predict_decimal_text(input logic signed [VW-1:0] v);
		logic [VW-1:0] mag;
		logic [3:0]    digits[20];
		int            n;
		char_exp_t     e;
		mag = v[VW-1] ? (~v + 1'b1) : v;
		n = 0;
		do begin
			digits[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0 && n < 20);
		if (v[VW-1]) begin
			e.ch   = CHAR_MINUS;
			e.last = 1'b0;
			expected_chars.push_back(e);
		end
		for (int k = n - 1; k >= 0; k--) begin
			e.ch   = CHAR_ZERO + CHAR_W'(digits[k]);
			e.last = (k == 0);
			expected_chars.push_back(e);
		end
	endfunction

	task automatic send_value(input logic signed [VW-1:0] v);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		push  <= 1'b1;
		value <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_decimal_text(v);
		values_sent++;
		if (v[VW-1]) negatives_sent++;
		burst_left--;
	endtask

	task automatic test_directed_extremes();
		logic signed [VW-1:0] list[$];
		list = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
			VAL_MAX, VAL_MIN, VAL_MIN + 1, VAL_MAX - 1,
			1000000000, -1000000000, 999999999, -999999999, -2000000000,
			32'h5555_5555, 32'hAAAA_AAAA};
		foreach (list[i]) send_value(list[i]);
	endtask

	task automatic test_random_words(input int count);
		repeat (count) send_value(VW'($urandom()));
	endtask

	// Pick a digit count first so short and long texts both show up often.
	task automatic test_random_lengths(input int count);
		longint lo;
		longint hi;
		int     n;
		longint mag;
		repeat (count) begin
			n  = $urandom_range(1, 10);
			lo = (n == 1) ? 0 : 1;
			for (int i = 1; i < n; i++) lo = lo * 10;
			hi = lo * 10 - 1;
			if (n == 1) hi = 9;
			if (hi > longint'(VAL_MAX)) hi = longint'(VAL_MAX);
			mag = $urandom_range(int'(hi), int'(lo));
			send_value($urandom_range(0, 1) ? VW'(-mag) : VW'(mag));
		end
	endtask

	// Check each character popped and choose the next pop.
	always @(posedge clk) begin
		char_exp_t e;
		if (arst_n) begin
			cycles++;
			if (pop && !empty) begin
				chars_checked++;
				if (expected_chars.size() == 0) begin
					errors++;
					$display("%0t: unexpected character %0d last %0b", $time, character,
						last_char);
				end else begin
					e = expected_chars.pop_front();
					if (character !== e.ch) begin
						errors++;
						$display("%0t: character expected %0d actual %0d", $time, e.ch,
							character);
					end
					if (last_char !== e.last) begin
						errors++;
						$display("%0t: last_char expected %0b actual %0b", $time, e.last,
							last_char);
					end
				end
			end
			if (mode_left == 0) begin
				pop_mode  = pop_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			case (pop_mode)
				POP_ALWAYS: pop <= 1'b1;
				POP_RANDOM: pop <= ($urandom_range(0, 3) != 0);
				POP_SLOW:   pop <= (cycles % 5 == 0);
				POP_RARE:   pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters outstanding", cycles,
				expected_chars.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		errors         = 0;
		cycles         = 0;
		values_sent    = 0;
		negatives_sent = 0;
		chars_checked  = 0;
		burst_left     = 0;
		mode_left      = 0;
		pop_mode       = POP_ALWAYS;
		arst_n         = 1'b0;
		push           = 1'b0;
		pop            = 1'b0;
		value          = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_random_words(150);
		test_random_lengths(207);

		push <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Converted %0d values (%0d negative), checked %0d characters.",
			values_sent, negatives_sent, chars_checked);
		$display("Covered zero, both extremes and every text length from 1 to 11 characters.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
